@@ src/assert_macros.svh @@
// Assertion macros shared by the decoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ src/htd_pkg.sv @@
// Shared types and constants of the Huffman tree decoder.
// No dependencies.
`default_nettype none

package htd_pkg;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 9;
  localparam int SYM_W   = 8;
  localparam int TOTAL_W = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             run_last;
    logic             stream_last;
  } out_item_t;

  // Strobes from the input decode to the walker, at most one high.
  typedef struct packed {
    logic start;
    logic data;
    logic load;
  } walk_cmd_t;

endpackage

`default_nettype wire

@@ src/htd_ifs.sv @@
// Valid/ready channel interfaces for the decoder input and output.
// Depends on htd_pkg for field widths.
`default_nettype none

interface htd_in_if import htd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] node_index;
  logic             node_is_leaf;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] right_child;
  logic [SYM_W-1:0] leaf_symbol;
  logic [SYM_W-1:0] data_byte;

  modport source (
    output valid, command, node_index, node_is_leaf, left_child, right_child,
           leaf_symbol, data_byte,
    input  ready
  );
  modport sink (
    input  valid, command, node_index, node_is_leaf, left_child, right_child,
           leaf_symbol, data_byte,
    output ready
  );
endinterface

interface htd_out_if import htd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             run_last;
  logic             stream_last;

  modport source (output valid, symbol, run_last, stream_last, input ready);
  modport sink (input valid, symbol, run_last, stream_last, output ready);
endinterface

`default_nettype wire

@@ src/huffman_tree_decoder.sv @@
// Huffman tree decoder: one coded bit per cycle, unless dout stalls, through a
// registered node table read. Load and start transactions leave the walker idle;
// a data byte steps through accept, up to 8 bit reads, last read resolve and flush
// and waits while dout stalls. Symbols pass a hold register and htd_out_reg.
// Synchronous reset sets walk index to root, clears symbol count and symbol_total;
// the node table is not cleared and reads as garbage until loaded.
`default_nettype none

module huffman_tree_decoder import htd_pkg::*; #(
  parameter int NODE_COUNT = 512
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [TOTAL_W-1:0] cfg_wr_data,
  htd_in_if.sink                  din,
  htd_out_if.source               dout
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [IW:0] NODE_LIM = (IW + 1)'(NODE_COUNT);

  logic [TOTAL_W-1:0] symbol_total;
  logic               accept;
  logic [IW-1:0]      idx_ext;
  logic               load_ok;
  walk_cmd_t          cmd;
  node_t              load_data;
  logic               idle;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  node_t              rd_data;
  logic               push;
  out_item_t          push_item;
  logic               out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_total <= '0;
    end else if (cfg_wr_en) begin
      symbol_total <= cfg_wr_data;
    end
  end

  assign din.ready = idle;
  assign accept    = din.valid && din.ready;
  assign idx_ext   = IW'(din.node_index);
  assign load_ok   = {1'b0, idx_ext} < NODE_LIM;

  always_comb begin
    cmd.load  = accept && (din.command == CMD_LOAD) && load_ok;
    cmd.data  = accept && (din.command == CMD_DATA);
    cmd.start = accept && (din.command == CMD_START);
    load_data.leaf  = din.node_is_leaf;
    load_data.left  = din.left_child;
    load_data.right = din.right_child;
    load_data.sym   = din.leaf_symbol;
  end

  htd_node_mem #(.NODE_COUNT(NODE_COUNT)) u_mem (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (load_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  htd_walker #(.NODE_COUNT(NODE_COUNT)) u_walker (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .data_bits    (din.data_byte),
    .load_addr    (idx_ext[AW-1:0]),
    .load_data    (load_data),
    .symbol_total (symbol_total),
    .idle         (idle),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .push         (push),
    .push_item    (push_item),
    .out_free     (out_free)
  );

  htd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .free      (out_free),
    .dout      (dout)
  );

endmodule

`default_nettype wire

@@ src/htd_node_mem.sv @@
// Node table: one write port, one read port with registered read data.
// Depends on htd_pkg for the node entry type.
`default_nettype none

module htd_node_mem import htd_pkg::*; #(
  parameter int NODE_COUNT = 512
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(NODE_COUNT)-1:0] wr_addr,
  input  wire node_t                         wr_data,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(NODE_COUNT)-1:0] rd_addr,
  output node_t                              rd_data
);

  node_t mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued, so a stalled walk keeps it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/htd_out_reg.sv @@
// Output register of the decoder result channel.
// Depends on htd_pkg, htd_out_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module htd_out_reg import htd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire out_item_t push_item,
  output logic           free,
  htd_out_if.source      dout
);

  logic      valid;
  out_item_t item;

  assign free             = !valid || dout.ready;
  assign dout.valid       = valid;
  assign dout.symbol      = item.symbol;
  assign dout.run_last    = item.run_last;
  assign dout.stream_last = item.stream_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (dout.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item <= push_item;
    end
  end

  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, push, free, "symbol pushed over a pending one")

endmodule

`default_nettype wire

@@ src/htd_walker.sv @@
// Tree walker: shifts a data byte out LSB first, at most one node read per bit,
// holds each symbol until it is known whether it is the last of its byte.
// Depends on htd_pkg and assert_macros.svh; drives htd_node_mem read port and htd_out_reg.
`default_nettype none
`include "assert_macros.svh"

module htd_walker import htd_pkg::*; #(
  parameter int NODE_COUNT = 512
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire walk_cmd_t                     cmd,
  input  wire logic [SYM_W-1:0]              data_bits,
  input  wire logic [$clog2(NODE_COUNT)-1:0] load_addr,
  input  wire node_t                         load_data,
  input  wire logic [TOTAL_W-1:0]            symbol_total,
  output logic                               idle,
  output logic                               rd_en,
  output logic [$clog2(NODE_COUNT)-1:0]      rd_addr,
  input  wire node_t                         rd_data,
  output logic                               push,
  output out_item_t                          push_item,
  input  wire logic                          out_free
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [IW:0] NODE_LIM = (IW + 1)'(NODE_COUNT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]         state;
  logic [SYM_W-1:0]   sh;
  logic [3:0]         bits_left;
  logic               pend;
  logic [AW-1:0]      pend_idx;
  node_t              cur;
  logic [AW-1:0]      cur_idx;
  node_t              root;
  logic [TOTAL_W-1:0] count;
  logic               hold_v;
  logic [SYM_W-1:0]   hold_sym;
  logic               hold_sl;

  logic               emit;
  logic               stall;
  logic [TOTAL_W-1:0] cnt_eff;
  logic               done;
  node_t              cur_eff;
  logic [AW-1:0]      idx_eff;
  logic [IDX_W-1:0]   child;
  logic [IW-1:0]      child_ext;
  logic               in_range;
  logic               issue;

  // Resolve the pending read (a leaf emits and returns to root) and issue the next.
  always_comb begin
    emit      = (state == ST_RUN) && pend && rd_data.leaf;
    stall     = emit && hold_v && !out_free;
    cnt_eff   = count + {{(TOTAL_W-1){1'b0}}, emit};
    done      = cnt_eff >= symbol_total;
    cur_eff   = !pend ? cur : (rd_data.leaf ? root : rd_data);
    idx_eff   = !pend ? cur_idx : (rd_data.leaf ? '0 : pend_idx);
    child     = sh[0] ? cur_eff.right : cur_eff.left;
    child_ext = IW'(child);
    in_range  = {1'b0, child_ext} < NODE_LIM;
    issue     = (state == ST_RUN) && !stall && (bits_left != 4'd0) && !done;
    rd_en     = issue && in_range;
    rd_addr   = child_ext[AW-1:0];
  end

  always_comb begin
    push                  = 1'b0;
    push_item.symbol      = hold_sym;
    push_item.stream_last = hold_sl;
    push_item.run_last    = 1'b0;
    case (state)
      ST_RUN: begin
        push = emit && hold_v && !stall;
      end
      ST_FLUSH: begin
        push               = hold_v && out_free;
        push_item.run_last = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign idle = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pend    <= 1'b0;
      hold_v  <= 1'b0;
      count   <= '0;
      cur_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            count   <= '0;
            cur     <= root;
            cur_idx <= '0;
          end
          if (cmd.load) begin
            // keep the cached root and current entries coherent with the table
            if (load_addr == '0) begin
              root <= load_data;
            end
            if (load_addr == cur_idx) begin
              cur <= load_data;
            end
          end
          if (cmd.data) begin
            sh        <= data_bits;
            bits_left <= 4'd8;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!stall) begin
            pend <= rd_en;
            if (rd_en) begin
              pend_idx <= rd_addr;
            end
            if (issue && !in_range) begin
              cur     <= root;
              cur_idx <= '0;
            end else begin
              cur     <= cur_eff;
              cur_idx <= idx_eff;
            end
            if (issue) begin
              sh        <= sh >> 1;
              bits_left <= bits_left - 4'd1;
            end
            if (emit) begin
              count    <= cnt_eff;
              hold_v   <= 1'b1;
              hold_sym <= rd_data.sym;
              hold_sl  <= (cnt_eff == symbol_total);
            end
            if (!issue) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!hold_v) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            hold_v <= 1'b0;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_rd_in_run, clk, rst, rd_en, state == ST_RUN, "node read outside a walk")
  `ASSERT_IMPLIES(a_idle_clean, clk, rst, state == ST_IDLE, !pend && !hold_v, "walk left residue")
  `ASSERT_IMPLIES(a_push_held, clk, rst, push, hold_v, "push without a held symbol")
  `ASSERT_ALWAYS(a_stall_run, clk, rst, !stall || (state == ST_RUN && hold_v), "bad stall")

endmodule

`default_nettype wire
